>>> hw/rtl/gcd_pkg.sv
package gcd_pkg;

  localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;
  localparam logic [63:0] QUARTER = 64'h1000_0000_0000_0000;
  localparam logic [63:0] EIGHTH  = 64'h0800_0000_0000_0000;
  localparam logic [63:0] PI_Q60  = 64'h3243_F6A8_885A_308D;

  // reciprocal of 360 for dividends below 2^63, quotient is (x * M360) >> 72
  localparam int unsigned  DIV360_SHIFT = 72;
  localparam logic [127:0] M360_WIDE = ((128'd1 << DIV360_SHIFT) / 128'd360) + 128'd1;
  localparam logic [63:0]  M360      = M360_WIDE[63:0];

  localparam logic [22:0] RADIUS_RESET = 23'd1632803;
  localparam logic [24:0] RESULT_MAX   = 25'h1FF_FFFF;

  // cycles from phase in to sine and cosine out of one evaluation
  localparam int unsigned SC_LAT = 43;

endpackage

>>> hw/rtl/great_circle_distance.sv
// throughput: one point pair per cycle, busy_o stays low
// the latency is mostly set by the 60-step arcsine search, each step a full
// pipelined sine evaluation plus a squaring multiplier and a compare
// reset clears the valid chain and sets the radius to 6378.137 km;
// the receiver cannot stall, so every result is shown for one cycle
module great_circle_distance #(
  parameter int unsigned ANGLE_FRAC_BITS = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [27:0] first_latitude_i,
  input  logic signed [28:0] first_longitude_i,
  input  logic signed [27:0] second_latitude_i,
  input  logic signed [28:0] second_longitude_i,
  input  logic               cfg_we_i,
  input  logic [22:0]        cfg_wdata_i,
  output logic               done_o,
  output logic [24:0]        arc_distance_o
);
  import gcd_pkg::*;

  localparam int unsigned KF  = 62 - ANGLE_FRAC_BITS;
  localparam int unsigned KH  = 61 - ANGLE_FRAC_BITS;
  localparam int unsigned LAT = 6 + SC_LAT + 5 + 60 * (SC_LAT + 3) + 5;

  logic [LAT-1:0]     vld_q;
  logic [22:0]        radius_q;
  logic signed [30:0] val [4];
  logic [30:0]        mag_q [4];
  logic               neg_q [4];
  logic [61:0]        phase_q [4];
  logic signed [63:0] sin_w [4];
  logic signed [63:0] cos_w [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      radius_q <= RADIUS_RESET;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start_i};
      if (cfg_we_i) begin
        radius_q <= cfg_wdata_i;
      end
    end
  end

  assign busy_o = 1'b0;
  assign done_o = vld_q[LAT-1];

  // differences for the haversine terms (halved by the phase scale), whole latitudes for the cosines
  assign val[0] = 31'(first_latitude_i) - 31'(second_latitude_i);
  assign val[1] = 31'(first_longitude_i) - 31'(second_longitude_i);
  assign val[2] = 31'(first_latitude_i);
  assign val[3] = 31'(second_latitude_i);

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 4; l++) begin
      neg_q[l] <= val[l][30];
      mag_q[l] <= val[l][30] ? 31'(-val[l]) : 31'(val[l]);
    end
  end

  // degrees to phase: split by 360, then round the remainder scaled up
  for (genvar l = 0; l < 4; l++) begin : g_lane
    localparam int unsigned K = (l < 2) ? KH : KF;
    logic [127:0] p1, p2;
    logic [30:0]  mag_d;
    logic [23:0]  q1, q1_d;
    logic [8:0]   rem;
    logic         neg_d;
    logic [61:0]  ph;

    gcd_mul u_m1 (.clk_i, .a_i({33'b0, mag_q[l]}), .b_i(M360), .p_o(p1));
    gcd_delay #(.W(31), .N(2)) u_dly_mag (.clk_i, .d_i(mag_q[l]), .q_o(mag_d));
    assign q1  = p1[95:72];
    assign rem = 9'(mag_d - 31'(q1) * 31'd360);

    gcd_mul u_m2 (.clk_i, .a_i((64'(rem) << K) + 64'd180), .b_i(M360), .p_o(p2));
    gcd_delay #(.W(24), .N(2)) u_dly_q (.clk_i, .d_i(q1), .q_o(q1_d));
    gcd_delay #(.W(1), .N(4)) u_dly_neg (.clk_i, .d_i(neg_q[l]), .q_o(neg_d));
    assign ph = (62'(q1_d) << K) + 62'(p2[127:72]);

    always_ff @(posedge clk_i) begin
      phase_q[l] <= neg_d ? 62'(0) - ph : ph;
    end

    gcd_sincos u_sc (.clk_i, .phase_i(phase_q[l]), .sin_o(sin_w[l]), .cos_o(cos_w[l]));
  end

  logic [63:0]  sa_m, sb_m, c1_m, c2_m, sa2, sa2_d, sb2, cc, t;
  logic [127:0] sa2_p, sb2_p, cc_p, t_p;
  logic         sub, sub_d;
  logic signed [65:0] hs;
  logic [62:0]  h_q;

  assign sa_m = sin_w[0][63] ? 64'(-sin_w[0]) : 64'(sin_w[0]);
  assign sb_m = sin_w[1][63] ? 64'(-sin_w[1]) : 64'(sin_w[1]);
  assign c1_m = cos_w[2][63] ? 64'(-cos_w[2]) : 64'(cos_w[2]);
  assign c2_m = cos_w[3][63] ? 64'(-cos_w[3]) : 64'(cos_w[3]);
  assign sub  = cos_w[2][63] ^ cos_w[3][63];

  gcd_mul u_sa2 (.clk_i, .a_i(sa_m), .b_i(sa_m), .p_o(sa2_p));
  gcd_mul u_sb2 (.clk_i, .a_i(sb_m), .b_i(sb_m), .p_o(sb2_p));
  gcd_mul u_cc  (.clk_i, .a_i(c1_m), .b_i(c2_m), .p_o(cc_p));
  assign sa2 = sa2_p[125:62];
  assign sb2 = sb2_p[125:62];
  assign cc  = cc_p[125:62];

  gcd_mul u_t (.clk_i, .a_i(cc), .b_i(sb2), .p_o(t_p));
  assign t = t_p[125:62];
  gcd_delay #(.W(64), .N(2)) u_dly_sa2 (.clk_i, .d_i(sa2), .q_o(sa2_d));
  gcd_delay #(.W(1), .N(4)) u_dly_sub (.clk_i, .d_i(sub), .q_o(sub_d));

  assign hs = sub_d ? $signed({2'b0, sa2_d}) - $signed({2'b0, t})
                    : $signed({2'b0, sa2_d}) + $signed({2'b0, t});

  // clamp the haversine term to [0, 1]
  always_ff @(posedge clk_i) begin
    priority if (hs[65]) begin
      h_q <= '0;
    end else if (hs > $signed({2'b0, ONE_Q62})) begin
      h_q <= ONE_Q62[62:0];
    end else begin
      h_q <= hs[62:0];
    end
  end

  // arcsine of the square root, one phase bit per step from the top
  logic [59:0] theta_s [0:60];
  logic [62:0] h_s [0:60];

  assign theta_s[0] = '0;
  assign h_s[0]     = h_q;

  for (genvar i = 0; i < 60; i++) begin : g_srch
    localparam int unsigned B = 59 - i;
    logic [59:0]  cand, cand_d;
    logic [62:0]  h_d;
    logic signed [63:0] s_w;
    logic [127:0] sq_p;

    assign cand = theta_s[i] | (60'(1) << B);
    gcd_sincos u_sc (.clk_i, .phase_i({2'b0, cand}), .sin_o(s_w), .cos_o());
    gcd_mul u_sq (.clk_i, .a_i(64'(s_w)), .b_i(64'(s_w)), .p_o(sq_p));
    gcd_delay #(.W(60), .N(SC_LAT + 2)) u_dly_c (.clk_i, .d_i(cand), .q_o(cand_d));
    gcd_delay #(.W(63), .N(SC_LAT + 2)) u_dly_h (.clk_i, .d_i(h_s[i]), .q_o(h_d));

    always_ff @(posedge clk_i) begin
      theta_s[i+1] <= (sq_p[125:62] <= {1'b0, h_d}) ? cand_d : cand_d & ~(60'(1) << B);
      h_s[i+1]     <= h_d;
    end
  end

  logic [63:0]  theta_f, ang, raw;
  logic [127:0] ang_p, raw_p;
  logic [64:0]  res;
  logic [24:0]  arc_q;

  assign theta_f = (h_s[60] == ONE_Q62[62:0]) ? QUARTER : {4'b0, theta_s[60]};

  gcd_mul u_ang (.clk_i, .a_i(theta_f), .b_i(PI_Q60), .p_o(ang_p));
  assign ang = ang_p[123:60];
  gcd_mul u_raw (.clk_i, .a_i(ang), .b_i({41'b0, radius_q}), .p_o(raw_p));
  assign raw = raw_p[122:59];
  assign res = (65'(raw) + 65'd1) >> 1;

  always_ff @(posedge clk_i) begin
    arc_q <= (res > 65'(RESULT_MAX)) ? RESULT_MAX : res[24:0];
  end

  assign arc_distance_o = arc_q;

endmodule

>>> hw/rtl/gcd_mul.sv
module gcd_mul (
  input  logic         clk_i,
  input  logic [63:0]  a_i,
  input  logic [63:0]  b_i,
  output logic [127:0] p_o
);
  logic [63:0]  pp_q [4];
  logic [127:0] p_q;

  // four 32x32 partial products, summed in the next cycle
  always_ff @(posedge clk_i) begin
    pp_q[0] <= 64'(a_i[31:0]) * 64'(b_i[31:0]);
    pp_q[1] <= 64'(a_i[31:0]) * 64'(b_i[63:32]);
    pp_q[2] <= 64'(a_i[63:32]) * 64'(b_i[31:0]);
    pp_q[3] <= 64'(a_i[63:32]) * 64'(b_i[63:32]);
    p_q     <= 128'(pp_q[0]) + (128'(pp_q[1]) << 32) + (128'(pp_q[2]) << 32)
             + (128'(pp_q[3]) << 64);
  end

  assign p_o = p_q;

endmodule

>>> hw/rtl/gcd_delay.sv
module gcd_delay #(
  parameter int unsigned W = 1,
  parameter int unsigned N = 1
) (
  input  logic         clk_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);
  logic [W-1:0] sr_q [N];

  always_ff @(posedge clk_i) begin
    sr_q[0] <= d_i;
    for (int i = 1; i < int'(N); i++) begin
      sr_q[i] <= sr_q[i-1];
    end
  end

  assign q_o = sr_q[N-1];

endmodule

>>> hw/rtl/gcd_sincos.sv
module gcd_sincos (
  input  logic               clk_i,
  input  logic [61:0]        phase_i,
  output logic signed [63:0] sin_o,
  output logic signed [63:0] cos_o
);
  import gcd_pkg::*;

  logic [1:0]   quad;
  logic [63:0]  frac;
  logic         swap;
  logic [63:0]  g;
  logic [127:0] r_prod, r2_prod, sn_prod;
  logic [63:0]  r, r2, r_d, sn, cs_d;
  logic [63:0]  r2_sr [1:32];
  logic [63:0]  tc [0:9];
  logic [63:0]  ts [0:8];
  logic [2:0]   qs_d;
  logic [63:0]  sn_x, cs_x;
  logic signed [63:0] sin_q, cos_q;

  // fold onto the first eighth of a turn
  assign quad = phase_i[61:60];
  assign frac = {4'b0, phase_i[59:0]};
  assign swap = frac > EIGHTH;
  assign g    = swap ? QUARTER - frac : frac;

  gcd_mul u_mul_r (.clk_i, .a_i(g), .b_i(PI_Q60), .p_o(r_prod));
  assign r = r_prod[122:59];

  gcd_mul u_mul_r2 (.clk_i, .a_i(r), .b_i(r), .p_o(r2_prod));
  assign r2 = r2_prod[125:62];

  always_ff @(posedge clk_i) begin
    r2_sr[1] <= r2;
    for (int m = 2; m <= 32; m++) begin
      r2_sr[m] <= r2_sr[m-1];
    end
  end

  // cosine series, one horner step per pair of multipliers
  assign tc[0] = ONE_Q62;
  for (genvar j = 0; j < 9; j++) begin : g_cos
    localparam int K = 9 - j;
    localparam int D = (2 * K - 1) * (2 * K);
    localparam int L = $clog2(D);
    localparam logic [127:0] MW = ((128'd1 << (62 + L)) / D) + 128'd1;
    logic [63:0]  tap;
    logic [127:0] pa, pb;
    if (j == 0) begin : g_t0
      assign tap = r2;
    end else begin : g_tn
      assign tap = r2_sr[4*j];
    end
    gcd_mul u_a (.clk_i, .a_i(tap), .b_i(tc[j]), .p_o(pa));
    gcd_mul u_b (.clk_i, .a_i(pa[125:62]), .b_i(MW[63:0]), .p_o(pb));
    assign tc[j+1] = ONE_Q62 - 64'(pb >> (62 + L));
  end

  // sine series starts one step later so both end together
  assign ts[0] = ONE_Q62;
  for (genvar j = 0; j < 8; j++) begin : g_sin
    localparam int K = 8 - j;
    localparam int D = (2 * K) * (2 * K + 1);
    localparam int L = $clog2(D);
    localparam logic [127:0] MW = ((128'd1 << (62 + L)) / D) + 128'd1;
    logic [127:0] pa, pb;
    gcd_mul u_a (.clk_i, .a_i(r2_sr[4*j+4]), .b_i(ts[j]), .p_o(pa));
    gcd_mul u_b (.clk_i, .a_i(pa[125:62]), .b_i(MW[63:0]), .p_o(pb));
    assign ts[j+1] = ONE_Q62 - 64'(pb >> (62 + L));
  end

  gcd_delay #(.W(64), .N(38)) u_dly_r (.clk_i, .d_i(r), .q_o(r_d));
  gcd_mul u_mul_sn (.clk_i, .a_i(r_d), .b_i(ts[8]), .p_o(sn_prod));
  assign sn = sn_prod[125:62];

  gcd_delay #(.W(64), .N(2)) u_dly_cs (.clk_i, .d_i(tc[9]), .q_o(cs_d));
  gcd_delay #(.W(3), .N(42)) u_dly_q (.clk_i, .d_i({quad, swap}), .q_o(qs_d));

  assign sn_x = qs_d[0] ? cs_d : sn;
  assign cs_x = qs_d[0] ? sn : cs_d;

  always_ff @(posedge clk_i) begin
    unique case (qs_d[2:1])
      2'd0: begin
        sin_q <= $signed(sn_x);
        cos_q <= $signed(cs_x);
      end
      2'd1: begin
        sin_q <= $signed(cs_x);
        cos_q <= -$signed(sn_x);
      end
      2'd2: begin
        sin_q <= -$signed(sn_x);
        cos_q <= -$signed(cs_x);
      end
      default: begin
        sin_q <= -$signed(cs_x);
        cos_q <= $signed(sn_x);
      end
    endcase
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule
